@@ rtl/core/hpg_pkg.sv @@
// Shared constants and types for the haptic pattern generator.
package hpg_pkg;

    // Default sizes
    localparam int HPG_TIMER_WIDTH  = 32;
    localparam int HPG_SINE_ENTRIES = 256;

    // Drive levels, Q0.16 with full drive as 65535
    localparam logic [15:0] LVL_ZERO   = 16'd0;
    localparam logic [15:0] LVL_FULL   = 16'd65535;
    localparam logic [15:0] LVL_HIGH   = 16'd52428;
    localparam logic [15:0] LVL_LOW    = 16'd45875;
    localparam logic [15:0] LVL_MED    = 16'd22937;
    localparam logic [15:0] LVL_IMPACT = 16'd773;
    localparam logic [15:0] LVL_HALF   = 16'd32768;
    localparam logic [15:0] LVL_FIFTH  = 16'd13107;

    // Ramp steps and ceilings for low, medium and high
    localparam logic [15:0] RAMP_STEP_L = 16'd655;
    localparam logic [15:0] RAMP_STEP_M = 16'd3277;
    localparam logic [15:0] RAMP_STEP_H = 16'd6554;
    localparam logic [15:0] RAMP_CEIL_L = 16'd19661;
    localparam logic [15:0] RAMP_CEIL_M = 16'd32768;
    localparam logic [15:0] RAMP_CEIL_H = 16'd65535;

    // Pattern timing in microseconds
    localparam int T_RAMP_STEP  = 500000;
    localparam int T_WALK_ON    = 200000;
    localparam int T_WALK_OFF   = 400000;
    localparam int T_BEAT       = 1000000;
    localparam int T_BEAT_GAP   = 200000;
    localparam int T_BURST_FULL = 100000;
    localparam int T_BURST_HALF = 300000;
    localparam int T_BURST_LOW  = 500000;
    localparam int PULSE_HALF   = 100000;
    localparam int PULSE_PERIOD = 200000;
    localparam int SWEEP_PERIOD = 1000000;

    // Residue register widths and their pre-reduction sum widths
    localparam int PULSE_RES_W = 18;
    localparam int PULSE_SUM_W = 20;
    localparam int SWEEP_RES_W = 20;
    localparam int SWEEP_SUM_W = 22;

    // Noise source: Galois LFSR, right shift
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Reduction of the noise word modulo 100 by reciprocal multiply
    localparam int          RUMBLE_MOD    = 100;
    localparam int          RUMBLE_IDX_W  = 7;
    localparam int          RUMBLE_SHIFT  = 23;
    localparam logic [16:0] RUMBLE_RECIP  = 17'd83887;
    localparam int          RUMBLE_PROD_W = 33;
    localparam int          RUMBLE_QUOT_W = 10;

    // Sweep phase: divide by 10^6 as a shift by 6 and a divide by 15625
    localparam int SWEEP_PRESHIFT = 6;
    localparam int SWEEP_ODD      = 15625;
    localparam int SWEEP_ODD_BITS = 14;

    typedef enum logic [3:0] {
        EFF_OFF       = 4'd0,
        EFF_LOW       = 4'd1,
        EFF_MED       = 4'd2,
        EFF_HIGH      = 4'd3,
        EFF_RAMP_L    = 4'd4,
        EFF_RAMP_M    = 4'd5,
        EFF_RAMP_H    = 4'd6,
        EFF_IMPACT    = 4'd7,
        EFF_WALK      = 4'd8,
        EFF_HEARTBEAT = 4'd9,
        EFF_RUMBLE    = 4'd10,
        EFF_PULSE     = 4'd11,
        EFF_SWEEP     = 4'd12,
        EFF_BURST     = 4'd13
    } t_effect;

    // Where a beat's level finally comes from
    typedef enum logic [1:0] {
        KIND_FIXED  = 2'd0,
        KIND_RUMBLE = 2'd1,
        KIND_SWEEP  = 2'd2
    } t_kind;

endpackage

@@ rtl/core/hpg_sine_rom.sv @@
// Raised sine table for the sweep effect, registered read.
module hpg_sine_rom
    import hpg_pkg::*;
#(
    parameter int ENTRIES = HPG_SINE_ENTRIES
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [$clog2(ENTRIES)-1:0] i_addr,
    output logic [15:0]                o_data
);

    localparam logic [63:0] NN = 64'(ENTRIES);
    localparam logic [63:0] N5 = 64'd5 * NN * NN;

    logic [15:0] rom_tab [ENTRIES];
    logic [15:0] r_data;

    // Build each entry from the Bhaskara form of (1 + sin) / 2
    for (genvar g = 0; g < ENTRIES; g++) begin : g_entry
        localparam logic [63:0] X     = 64'(g) * 64'd2;
        localparam bit          UPPER = (X < NN);
        localparam logic [63:0] A     = UPPER ? X : (X - NN);
        localparam logic [63:0] T     = A * (NN - A);
        localparam logic [63:0] D     = N5 - 64'd4 * T;
        localparam logic [63:0] NUM   = UPPER ? (64'd65535 * (N5 + 64'd12 * T))
                                              : (64'd65535 * (N5 - 64'd20 * T));
        localparam logic [63:0] V     = (NUM + D) / (64'd2 * D);
        assign rom_tab[g] = (V > 64'(LVL_FULL)) ? LVL_FULL : 16'(V);
    end

    // Read and hold
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= rom_tab[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/core/haptic_pattern_generator.sv @@
// A result shows on o_valid once its tick beat has gone through the output register.
// Throughput: one tick per cycle while o_stall is low; the five stages are input,
// state update, noise/phase multiply, reciprocal multiply and table read, then the
// output register. Ticks that give no result leave a bubble and no output beat.
// Reset (synchronous, active low): timer 0, ramp level 0 rising, noise seed 0xACE1.
module haptic_pattern_generator
    import hpg_pkg::*;
#(
    parameter int TIMER_WIDTH  = HPG_TIMER_WIDTH,
    parameter int SINE_ENTRIES = HPG_SINE_ENTRIES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [19:0] i_elapsed_us,
    input  logic [3:0]  i_effect,
    input  logic [3:0]  i_controller_id,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_target_id,
    output logic [15:0] o_left_level,
    output logic [15:0] o_right_level
);

    // Sweep phase arithmetic sizes
    localparam int          KW        = $clog2(SINE_ENTRIES);
    localparam logic [63:0] PHASE_MAX = 64'(SWEEP_PERIOD - 1) * 64'(SINE_ENTRIES);
    localparam int          PW        = $clog2(PHASE_MAX + 64'd1);
    localparam int          QL        = PW - SWEEP_PRESHIFT;
    localparam int          DSHIFT    = QL + SWEEP_ODD_BITS;
    localparam int          RECIP_W   = QL + 1;
    localparam int          PROD2_W   = QL + RECIP_W;
    localparam logic [63:0] RECIP64   =
        ((64'd1 << DSHIFT) + 64'(SWEEP_ODD - 1)) / 64'(SWEEP_ODD);
    localparam logic [RECIP_W-1:0] DIV_RECIP = RECIP_W'(RECIP64);

    // Residue correction when the timer wraps past 2^TIMER_WIDTH
    localparam logic [TIMER_WIDTH:0] WRAP_SPAN = (TIMER_WIDTH+1)'(1) << TIMER_WIDTH;
    localparam logic [PULSE_RES_W-1:0] WRAP_P =
        PULSE_RES_W'(WRAP_SPAN % (TIMER_WIDTH+1)'(PULSE_PERIOD));
    localparam logic [SWEEP_RES_W-1:0] WRAP_S =
        SWEEP_RES_W'(WRAP_SPAN % (TIMER_WIDTH+1)'(SWEEP_PERIOD));
    localparam logic [PULSE_SUM_W-1:0] ADJ_P = PULSE_SUM_W'(PULSE_PERIOD) - PULSE_SUM_W'(WRAP_P);
    localparam logic [SWEEP_SUM_W-1:0] ADJ_S = SWEEP_SUM_W'(SWEEP_PERIOD) - SWEEP_SUM_W'(WRAP_S);

    // Stage ready chain
    logic s1_rdy, s2_rdy, s3_rdy, s4_rdy, s5_rdy, out_rdy;

    // Stage 1: input register
    logic                   r_s1_vld;
    logic [19:0]            r_s1_us;
    t_effect                r_s1_eff;
    logic [3:0]             r_s1_id;
    logic [PULSE_RES_W-1:0] r_s1_up;
    logic [SWEEP_RES_W-1:0] r_s1_us6;
    logic [PULSE_RES_W-1:0] in_up;
    logic [SWEEP_RES_W-1:0] in_us6;

    // State
    logic [TIMER_WIDTH-1:0] r_timer, n_timer;
    logic [PULSE_RES_W-1:0] r_res_p, n_res_p;
    logic [SWEEP_RES_W-1:0] r_res_s, n_res_s;
    logic [15:0]            r_ramp_lvl, n_ramp_lvl;
    logic                   r_ramp_up, n_ramp_up;
    logic [15:0]            r_noise, n_noise;

    // Stage 2 combinational terms
    logic [TIMER_WIDTH:0]   tsum;
    logic [TIMER_WIDTH-1:0] tnew;
    logic [PULSE_SUM_W-1:0] psum;
    logic [SWEEP_SUM_W-1:0] ssum;
    logic [PULSE_RES_W-1:0] p_adv;
    logic [SWEEP_RES_W-1:0] s_adv;
    logic [15:0]            ramp_step, ramp_ceil, ramp_lvl;
    logic [16:0]            ramp_sum;
    logic [15:0]            noise_next;
    logic                   s2_emit;
    logic [15:0]            s2_lvl;
    t_kind                  s2_kind;

    // Stage 2..5 and output registers
    logic                   r_s2_vld, r_s3_vld, r_s4_vld, r_s5_vld, r_out_vld;
    logic [3:0]             r_s2_id, r_s3_id, r_s4_id, r_s5_id, r_out_id;
    t_kind                  r_s2_kind, r_s3_kind, r_s4_kind, r_s5_kind;
    logic [15:0]            r_s2_lvl, r_s3_lvl, r_s4_lvl, r_s5_lvl, r_out_lvl;
    logic [15:0]            r_s2_noise, r_s3_noise;
    logic [SWEEP_RES_W-1:0] r_s2_phase;
    logic [RUMBLE_PROD_W-1:0] r_s3_rprod;
    logic [PW-1:0]          r_s3_sprod;
    logic [RUMBLE_IDX_W-1:0] r_s4_ridx;
    logic [PROD2_W-1:0]     r_s4_sprod;

    logic [RUMBLE_QUOT_W-1:0] rum_quot;
    logic [15:0]              rum_rem;
    logic [KW-1:0]            sweep_idx;
    logic [15:0]              sine_q;
    logic [15:0]              rum_tab [RUMBLE_MOD];

    // Advance a stage when it is empty or its contents move on
    assign out_rdy = !r_out_vld || !i_stall;
    assign s5_rdy  = !r_s5_vld || out_rdy;
    assign s4_rdy  = !r_s4_vld || s5_rdy;
    assign s3_rdy  = !r_s3_vld || s4_rdy;
    assign s2_rdy  = !r_s2_vld || s3_rdy;
    assign s1_rdy  = !r_s1_vld || s2_rdy;
    assign o_stall = !s1_rdy;

    // Reduce the elapsed time by the pulse and sweep periods
    always_comb begin
        priority if (i_elapsed_us >= 20'(5 * PULSE_PERIOD)) begin
            in_up = PULSE_RES_W'(i_elapsed_us - 20'(5 * PULSE_PERIOD));
        end else if (i_elapsed_us >= 20'(4 * PULSE_PERIOD)) begin
            in_up = PULSE_RES_W'(i_elapsed_us - 20'(4 * PULSE_PERIOD));
        end else if (i_elapsed_us >= 20'(3 * PULSE_PERIOD)) begin
            in_up = PULSE_RES_W'(i_elapsed_us - 20'(3 * PULSE_PERIOD));
        end else if (i_elapsed_us >= 20'(2 * PULSE_PERIOD)) begin
            in_up = PULSE_RES_W'(i_elapsed_us - 20'(2 * PULSE_PERIOD));
        end else if (i_elapsed_us >= 20'(PULSE_PERIOD)) begin
            in_up = PULSE_RES_W'(i_elapsed_us - 20'(PULSE_PERIOD));
        end else begin
            in_up = PULSE_RES_W'(i_elapsed_us);
        end
        in_us6 = (i_elapsed_us >= 20'(SWEEP_PERIOD)) ? (i_elapsed_us - 20'(SWEEP_PERIOD))
                                                     : i_elapsed_us;
    end

    // Stage 1: capture the tick beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (s1_rdy) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_us  <= i_elapsed_us;
            r_s1_eff <= t_effect'(i_effect);
            r_s1_id  <= i_controller_id;
            r_s1_up  <= in_up;
            r_s1_us6 <= in_us6;
        end
    end

    // Advance the timer and both of its residues
    always_comb begin
        tsum = (TIMER_WIDTH+1)'(r_timer) + (TIMER_WIDTH+1)'(r_s1_us);
        tnew = tsum[TIMER_WIDTH-1:0];
        psum = PULSE_SUM_W'(r_res_p) + PULSE_SUM_W'(r_s1_up)
             + (tsum[TIMER_WIDTH] ? ADJ_P : '0);
        ssum = SWEEP_SUM_W'(r_res_s) + SWEEP_SUM_W'(r_s1_us6)
             + (tsum[TIMER_WIDTH] ? ADJ_S : '0);
        priority if (psum >= PULSE_SUM_W'(2 * PULSE_PERIOD)) begin
            p_adv = PULSE_RES_W'(psum - PULSE_SUM_W'(2 * PULSE_PERIOD));
        end else if (psum >= PULSE_SUM_W'(PULSE_PERIOD)) begin
            p_adv = PULSE_RES_W'(psum - PULSE_SUM_W'(PULSE_PERIOD));
        end else begin
            p_adv = PULSE_RES_W'(psum);
        end
        priority if (ssum >= SWEEP_SUM_W'(2 * SWEEP_PERIOD)) begin
            s_adv = SWEEP_RES_W'(ssum - SWEEP_SUM_W'(2 * SWEEP_PERIOD));
        end else if (ssum >= SWEEP_SUM_W'(SWEEP_PERIOD)) begin
            s_adv = SWEEP_RES_W'(ssum - SWEEP_SUM_W'(SWEEP_PERIOD));
        end else begin
            s_adv = SWEEP_RES_W'(ssum);
        end
    end

    // Pick ramp step and ceiling, step the noise source
    always_comb begin
        unique case (r_s1_eff)
            EFF_RAMP_L: begin
                ramp_step = RAMP_STEP_L;
                ramp_ceil = RAMP_CEIL_L;
            end
            EFF_RAMP_M: begin
                ramp_step = RAMP_STEP_M;
                ramp_ceil = RAMP_CEIL_M;
            end
            default: begin
                ramp_step = RAMP_STEP_H;
                ramp_ceil = RAMP_CEIL_H;
            end
        endcase
        ramp_sum   = 17'(r_ramp_lvl) + 17'(ramp_step);
        noise_next = r_noise[0] ? ((r_noise >> 1) ^ LFSR_TAPS) : (r_noise >> 1);
    end

    // Stage 2: effect decode and state update
    always_comb begin
        n_timer    = r_timer;
        n_res_p    = r_res_p;
        n_res_s    = r_res_s;
        n_ramp_lvl = r_ramp_lvl;
        n_ramp_up  = r_ramp_up;
        n_noise    = r_noise;
        ramp_lvl   = r_ramp_lvl;
        s2_emit    = 1'b1;
        s2_lvl     = LVL_ZERO;
        s2_kind    = KIND_FIXED;
        unique case (r_s1_eff)
            EFF_OFF:    s2_lvl = LVL_ZERO;
            EFF_LOW:    s2_lvl = LVL_LOW;
            EFF_MED:    s2_lvl = LVL_MED;
            EFF_HIGH:   s2_lvl = LVL_HIGH;
            EFF_IMPACT: s2_lvl = LVL_IMPACT;
            EFF_RAMP_L, EFF_RAMP_M, EFF_RAMP_H: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                if (tnew > TIMER_WIDTH'(T_RAMP_STEP)) begin
                    if (r_ramp_up) begin
                        ramp_lvl = (ramp_sum > 17'(ramp_ceil)) ? ramp_ceil : ramp_sum[15:0];
                    end else begin
                        ramp_lvl = (r_ramp_lvl > ramp_step) ? (r_ramp_lvl - ramp_step)
                                                            : LVL_ZERO;
                    end
                    n_timer = '0;
                    n_res_p = '0;
                    n_res_s = '0;
                end
                priority if (ramp_lvl >= ramp_ceil) begin
                    n_ramp_up = 1'b0;
                end else if (ramp_lvl == LVL_ZERO) begin
                    n_ramp_up = 1'b1;
                end
                n_ramp_lvl = ramp_lvl;
                s2_lvl     = ramp_lvl;
            end
            EFF_WALK: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                priority if (tnew < TIMER_WIDTH'(T_WALK_ON)) begin
                    s2_lvl = LVL_IMPACT;
                end else if (tnew < TIMER_WIDTH'(T_WALK_OFF)) begin
                    s2_lvl = LVL_ZERO;
                end else begin
                    n_timer = '0;
                    n_res_p = '0;
                    n_res_s = '0;
                    s2_emit = 1'b0;
                end
            end
            EFF_HEARTBEAT: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                priority if (tnew > TIMER_WIDTH'(T_BEAT)) begin
                    s2_lvl  = LVL_HIGH;
                    n_timer = '0;
                    n_res_p = '0;
                    n_res_s = '0;
                end else if (tnew > TIMER_WIDTH'(T_BEAT_GAP)) begin
                    s2_lvl = LVL_ZERO;
                end else begin
                    s2_emit = 1'b0;
                end
            end
            EFF_RUMBLE: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                n_noise = noise_next;
                s2_kind = KIND_RUMBLE;
            end
            EFF_PULSE: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                s2_lvl  = (p_adv >= PULSE_RES_W'(PULSE_HALF)) ? LVL_ZERO : LVL_HIGH;
            end
            EFF_SWEEP: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                s2_kind = KIND_SWEEP;
            end
            EFF_BURST: begin
                n_timer = tnew;
                n_res_p = p_adv;
                n_res_s = s_adv;
                priority if (tnew < TIMER_WIDTH'(T_BURST_FULL)) begin
                    s2_lvl = LVL_FULL;
                end else if (tnew < TIMER_WIDTH'(T_BURST_HALF)) begin
                    s2_lvl = LVL_HALF;
                end else if (tnew < TIMER_WIDTH'(T_BURST_LOW)) begin
                    s2_lvl = LVL_FIFTH;
                end else begin
                    s2_lvl  = LVL_ZERO;
                    n_timer = '0;
                    n_res_p = '0;
                    n_res_s = '0;
                end
            end
            default: s2_lvl = LVL_ZERO;
        endcase
    end

    // Commit state only when a tick moves into stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timer    <= '0;
            r_res_p    <= '0;
            r_res_s    <= '0;
            r_ramp_lvl <= LVL_ZERO;
            r_ramp_up  <= 1'b1;
            r_noise    <= LFSR_SEED;
        end else if (s2_rdy && r_s1_vld) begin
            r_timer    <= n_timer;
            r_res_p    <= n_res_p;
            r_res_s    <= n_res_s;
            r_ramp_lvl <= n_ramp_lvl;
            r_ramp_up  <= n_ramp_up;
            r_noise    <= n_noise;
        end
    end

    // Pipeline valid bits; ticks without a result drop out here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_s5_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s2_rdy) begin
                r_s2_vld <= r_s1_vld && s2_emit;
            end
            if (s3_rdy) begin
                r_s3_vld <= r_s2_vld;
            end
            if (s4_rdy) begin
                r_s4_vld <= r_s3_vld;
            end
            if (s5_rdy) begin
                r_s5_vld <= r_s4_vld;
            end
            if (out_rdy) begin
                r_out_vld <= r_s5_vld;
            end
        end
    end

    // Stage 2 payload
    always_ff @(posedge i_clk) begin
        if (s2_rdy) begin
            r_s2_id    <= r_s1_id;
            r_s2_kind  <= s2_kind;
            r_s2_lvl   <= s2_lvl;
            r_s2_noise <= n_noise;
            r_s2_phase <= n_res_s;
        end
    end

    // Stage 3: noise reciprocal product and sweep phase product
    always_ff @(posedge i_clk) begin
        if (s3_rdy) begin
            r_s3_id    <= r_s2_id;
            r_s3_kind  <= r_s2_kind;
            r_s3_lvl   <= r_s2_lvl;
            r_s3_noise <= r_s2_noise;
            r_s3_rprod <= RUMBLE_PROD_W'(r_s2_noise) * RUMBLE_PROD_W'(RUMBLE_RECIP);
            r_s3_sprod <= PW'(r_s2_phase) * PW'(SINE_ENTRIES);
        end
    end

    // Stage 4: noise remainder, sweep divide by reciprocal
    assign rum_quot = r_s3_rprod[RUMBLE_SHIFT +: RUMBLE_QUOT_W];
    assign rum_rem  = r_s3_noise - 16'(rum_quot) * 16'(RUMBLE_MOD);

    always_ff @(posedge i_clk) begin
        if (s4_rdy) begin
            r_s4_id    <= r_s3_id;
            r_s4_kind  <= r_s3_kind;
            r_s4_lvl   <= r_s3_lvl;
            r_s4_ridx  <= rum_rem[RUMBLE_IDX_W-1:0];
            r_s4_sprod <= PROD2_W'(r_s3_sprod[PW-1:SWEEP_PRESHIFT]) * PROD2_W'(DIV_RECIP);
        end
    end

    // Rumble level table: (65535 * (100 + r) + 100) / 200
    for (genvar g = 0; g < RUMBLE_MOD; g++) begin : g_rum
        localparam logic [31:0] RV = (32'd65535 * 32'(RUMBLE_MOD + g) + 32'(RUMBLE_MOD))
                                     / 32'(2 * RUMBLE_MOD);
        assign rum_tab[g] = 16'(RV);
    end

    // Stage 5: table reads
    assign sweep_idx = KW'(r_s4_sprod >> DSHIFT);

    hpg_sine_rom #(
        .ENTRIES (SINE_ENTRIES)
    ) u_sine_rom (
        .i_clk  (i_clk),
        .i_en   (s5_rdy),
        .i_addr (sweep_idx),
        .o_data (sine_q)
    );

    always_ff @(posedge i_clk) begin
        if (s5_rdy) begin
            r_s5_id   <= r_s4_id;
            r_s5_kind <= r_s4_kind;
            r_s5_lvl  <= (r_s4_kind == KIND_RUMBLE) ? rum_tab[r_s4_ridx] : r_s4_lvl;
        end
    end

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (out_rdy) begin
            r_out_id  <= r_s5_id;
            r_out_lvl <= (r_s5_kind == KIND_SWEEP) ? sine_q : r_s5_lvl;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_target_id   = r_out_id;
    assign o_left_level  = r_out_lvl;
    assign o_right_level = r_out_lvl;

endmodule
